[hdl/llu_pkg.sv]
// Shared widths, scale constants and pipeline word types of the latency/loss utility unit.
`timescale 1ns / 1ps
package llu_pkg;

  // Field widths.
  localparam int RateW = 40;
  localparam int CntW  = 20;
  localparam int MssW  = 16;
  localparam int DurW  = 32;
  localparam int RttW  = 29;
  localparam int UtilW = 64;

  // Internal widths.
  localparam int DenW   = DurW - 1;     // positive part of a duration
  localparam int ThptW  = 56;           // throughput quotient
  localparam int ThrNW  = 37;           // threshold numerator and quotient
  localparam int RttKW  = 39;           // 1000 * |rtt change|
  localparam int LossNW = 30;           // 1000 * lost
  localparam int LossDW = CntW + 1;     // lost + delivered
  localparam int LossW  = 10;           // per mille loss ratio
  localparam int InflW  = 39;           // inflation magnitude
  localparam int WInfW  = 49;           // 900 * inflation
  localparam int WLosW  = 14;           // 11 * loss
  localparam int AmagW  = 50;           // |900 * infl + 11 * loss|
  localparam int HalfW  = AmagW / 2;
  localparam int PpW    = RateW + HalfW;
  localparam int ProdW  = RateW + AmagW;
  localparam int UqW    = 81;           // quotient of the product by 1000

  // Digit-wise divide by 1000: ten-bit digits, quotient digit by reciprocal multiply.
  localparam int LimbW   = 10;
  localparam int NLimb   = ProdW / LimbW;
  localparam int RecipW  = 21;
  localparam int RecipSh = 30;

  // Scale factors and limits.
  localparam logic [20:0] ThptScale  = 21'd1000000;
  localparam logic [21:0] ThrScale   = 22'd2000000;
  localparam logic [9:0]  InflScale  = 10'd1000;
  localparam logic [9:0]  LossScale  = 10'd1000;
  localparam logic [9:0]  InflWeight = 10'd900;
  localparam logic [3:0]  LossWeight = 4'd11;
  localparam logic [9:0]  UtilDiv    = 10'd1000;
  localparam logic [20:0] UtilRecip  = 21'd1073742;  // 2^30 / 1000, rounded up
  localparam logic [5:0]  InflMin    = 6'd30;
  localparam logic [6:0]  LossMin    = 7'd100;

  // Sideband that rides along the throughput divider.
  typedef struct packed {
    logic [RateW-1:0] rate;
    logic [ThrNW-1:0] thr_num;
    logic [RttW-1:0]  rtt_mag;
    logic             rtt_neg;
    logic             recv_pos;
    logic             none_del;
  } side1_t;

  // Word leaving the front stages.
  typedef struct packed {
    logic [ThptW-1:0]  thpt_num;
    logic [DenW-1:0]   recv_den;
    logic [RttKW-1:0]  rtt_k;
    logic [DenW-1:0]   send_den;
    logic              send_pos;
    logic [LossNW-1:0] loss_num;
    logic [LossDW-1:0] loss_den;
    logic              start;
    side1_t            side;
  } front_t;

  // Sideband that rides along the threshold divider.
  typedef struct packed {
    logic [RateW-1:0] rate;
    logic             thpt_pos;
    logic [RttW-1:0]  rtt_mag;
    logic [InflW-1:0] infl_mag;
    logic             infl_neg;
    logic [LossW-1:0] loss;
    logic             start;
    logic             none_del;
  } side2_t;

  // Sideband that rides along the final divide by 1000.
  typedef struct packed {
    logic [RateW-1:0] rate;
    logic             a_neg;
    logic             none_del;
  } side5_t;

endpackage

[hdl/llu_div.sv]
// Pipelined restoring divider, one quotient bit per register stage, with sideband.
`timescale 1ns / 1ps
module llu_div #(
  parameter int NUM_W  = 32,
  parameter int DEN_W  = 16,
  parameter int Q_W    = 16,
  parameter int SIDE_W = 1
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              en_i,
  input  logic              valid_i,
  input  logic [NUM_W-1:0]  num_i,
  input  logic [DEN_W-1:0]  den_i,
  input  logic [SIDE_W-1:0] side_i,
  output logic              valid_o,
  output logic [Q_W-1:0]    quot_o,
  output logic [SIDE_W-1:0] side_o
);

  // The caller guarantees that the quotient fits in Q_W bits.
  localparam int CW = (NUM_W > DEN_W + Q_W) ? NUM_W : DEN_W + Q_W;

  logic [Q_W-1:0]    vld_q;
  logic [NUM_W-1:0]  rem_q  [Q_W];
  logic [DEN_W-1:0]  den_q  [Q_W];
  logic [Q_W-1:0]    quo_q  [Q_W];
  logic [SIDE_W-1:0] side_q [Q_W];

  for (genvar k = 0; k < Q_W; k++) begin : g_stage
    logic              vld_in;
    logic [NUM_W-1:0]  rem_in;
    logic [DEN_W-1:0]  den_in;
    logic [Q_W-1:0]    quo_in;
    logic [SIDE_W-1:0] side_in;
    logic [CW-1:0]     rem_x;
    logic [CW-1:0]     den_x;
    logic              ge;
    logic [NUM_W-1:0]  rem_d;
    logic [Q_W-1:0]    quo_d;

    if (k == 0) begin : g_first
      assign vld_in  = valid_i;
      assign rem_in  = num_i;
      assign den_in  = den_i;
      assign quo_in  = '0;
      assign side_in = side_i;
    end else begin : g_next
      assign vld_in  = vld_q[k-1];
      assign rem_in  = rem_q[k-1];
      assign den_in  = den_q[k-1];
      assign quo_in  = quo_q[k-1];
      assign side_in = side_q[k-1];
    end

    always_comb begin
      rem_x = CW'(rem_in);
      den_x = CW'(den_in) << (Q_W - 1 - k);
      ge    = (rem_x >= den_x);
      rem_d = ge ? NUM_W'(rem_x - den_x) : rem_in;
      quo_d = quo_in;
      quo_d[Q_W-1-k] = ge;
    end

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        vld_q[k] <= 1'b0;
      end else if (en_i) begin
        vld_q[k] <= vld_in;
      end
    end

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        rem_q[k]  <= rem_d;
        den_q[k]  <= den_in;
        quo_q[k]  <= quo_d;
        side_q[k] <= side_in;
      end
    end
  end

  assign valid_o = vld_q[Q_W-1];
  assign quot_o  = quo_q[Q_W-1];
  assign side_o  = side_q[Q_W-1];

endmodule

[hdl/llu_front.sv]
// Two front stages that form the dividends, divisors and flags of one record.
`timescale 1ns / 1ps
module llu_front (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        en_i,
  input  logic                        valid_i,
  input  logic [llu_pkg::RateW-1:0]   send_rate_i,
  input  logic [llu_pkg::CntW-1:0]    delivered_count_i,
  input  logic [llu_pkg::CntW-1:0]    lost_count_i,
  input  logic [llu_pkg::MssW-1:0]    segment_size_i,
  input  logic signed [llu_pkg::DurW-1:0] send_duration_us_i,
  input  logic signed [llu_pkg::DurW-1:0] recv_duration_us_i,
  input  logic [llu_pkg::RttW-1:0]    start_rtt_us_i,
  input  logic [llu_pkg::RttW-1:0]    end_rtt_us_i,
  input  logic                        in_start_mode_i,
  output logic                        valid_o,
  output llu_pkg::front_t             front_o
);
  import llu_pkg::*;

  localparam int DmW = CntW + MssW;

  logic              vld_a_q, vld_b_q;
  logic [DmW-1:0]    dm_q;
  logic [RttW:0]     diff;
  front_t            a_d, a_q, b_d, b_q;

  always_comb begin
    diff = {1'b0, end_rtt_us_i} - {1'b0, start_rtt_us_i};
    a_d = '0;
    a_d.recv_den      = recv_duration_us_i[DenW-1:0];
    a_d.send_den      = send_duration_us_i[DenW-1:0];
    a_d.send_pos      = !send_duration_us_i[DurW-1] && (send_duration_us_i != '0);
    a_d.loss_num      = LossNW'(lost_count_i) * LossNW'(LossScale);
    a_d.loss_den      = LossDW'(lost_count_i) + LossDW'(delivered_count_i);
    a_d.start         = in_start_mode_i;
    a_d.side.rate     = send_rate_i;
    a_d.side.thr_num  = ThrNW'(segment_size_i) * ThrNW'(ThrScale);
    a_d.side.rtt_neg  = diff[RttW];
    a_d.side.rtt_mag  = diff[RttW] ? RttW'(-diff) : diff[RttW-1:0];
    a_d.side.recv_pos = !recv_duration_us_i[DurW-1] && (recv_duration_us_i != '0);
    a_d.side.none_del = (delivered_count_i == '0);
  end

  always_comb begin
    b_d = a_q;
    b_d.thpt_num = ThptW'(dm_q) * ThptW'(ThptScale);
    b_d.rtt_k    = RttKW'(a_q.side.rtt_mag) * RttKW'(InflScale);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_a_q <= 1'b0;
      vld_b_q <= 1'b0;
    end else if (en_i) begin
      vld_a_q <= valid_i;
      vld_b_q <= vld_a_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      dm_q <= DmW'(delivered_count_i) * DmW'(segment_size_i);
      a_q  <= a_d;
      b_q  <= b_d;
    end
  end

  assign valid_o = vld_b_q;
  assign front_o = b_q;

endmodule

[hdl/llu_util.sv]
// Stages that apply the inflation and loss rules and form rate times the penalty.
`timescale 1ns / 1ps
module llu_util (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       en_i,
  input  logic                       valid_i,
  input  logic [llu_pkg::ThrNW-1:0]  thresh_i,
  input  llu_pkg::side2_t            side_i,
  output logic                       valid_o,
  output logic [llu_pkg::ProdW-1:0]  prod_o,
  output llu_pkg::side5_t            side_o
);
  import llu_pkg::*;

  logic [4:0]        vld_q;

  // Stage E: inflation after the zeroing rules.
  logic [InflW-1:0]  infl_d, infl_q;
  logic              ineg_d, ineg_q;
  logic [LossW-1:0]  loss_e_q;
  side5_t            sd_e_q, sd_f_q, sd_g_q, sd_h_q, sd_i_q;
  logic              zero;

  // Stage F: weighted terms.
  logic [WInfW-1:0]  w_q;
  logic [WLosW-1:0]  l_q;
  logic              neg_f_q;

  // Stage G: penalty magnitude and sign.
  logic [AmagW-1:0]  wx, lx, amag_d, amag_q;
  logic              aneg_d;

  // Stages H and I: partial products and their sum.
  logic [PpW-1:0]    pl_q, ph_q;
  logic [ProdW-1:0]  prod_q;

  always_comb begin
    zero = (side_i.thpt_pos && (ThrNW'(side_i.rtt_mag) < thresh_i))
        || (side_i.infl_mag < InflW'(InflMin))
        || (side_i.infl_neg && side_i.start);
    infl_d = zero ? '0 : side_i.infl_mag;
    ineg_d = zero ? 1'b0 : side_i.infl_neg;
  end

  always_comb begin
    wx = AmagW'(w_q);
    lx = AmagW'(l_q);
    if (neg_f_q && (wx > lx)) begin
      amag_d = wx - lx;
      aneg_d = 1'b1;
    end else if (neg_f_q) begin
      amag_d = lx - wx;
      aneg_d = 1'b0;
    end else begin
      amag_d = wx + lx;
      aneg_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else if (en_i) begin
      vld_q <= {vld_q[3:0], valid_i};
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      infl_q   <= infl_d;
      ineg_q   <= ineg_d;
      loss_e_q <= side_i.loss;
      sd_e_q   <= side5_t'({side_i.rate, 1'b0, side_i.none_del});

      w_q     <= WInfW'(infl_q) * WInfW'(InflWeight);
      l_q     <= WLosW'(loss_e_q) * WLosW'(LossWeight);
      neg_f_q <= ineg_q;
      sd_f_q  <= sd_e_q;

      amag_q <= amag_d;
      sd_g_q <= side5_t'({sd_f_q.rate, aneg_d, sd_f_q.none_del});

      pl_q   <= PpW'(sd_g_q.rate) * PpW'(amag_q[HalfW-1:0]);
      ph_q   <= PpW'(sd_g_q.rate) * PpW'(amag_q[AmagW-1:HalfW]);
      sd_h_q <= sd_g_q;

      prod_q <= (ProdW'(ph_q) << HalfW) + ProdW'(pl_q);
      sd_i_q <= sd_h_q;
    end
  end

  assign valid_o = vld_q[4];
  assign prod_o  = prod_q;
  assign side_o  = sd_i_q;

endmodule

[hdl/latency_loss_utility_calc_unit.sv]
// Top level of the latency/loss utility unit: divider pipelines, saturation and output word.
//
//   Channel | Direction | Handshake             | Word
//   --------+-----------+-----------------------+----------------------------------------
//   in      | input     | in_valid_i / in_stall_o   | one monitor interval record
//   out     | output    | out_valid_o / out_stall_i | utility and none-delivered flag
//
// Every word passes, from acceptance to the output register, through two front stages,
// a 56-stage throughput divider (with the inflation and loss dividers beside it), a
// 37-stage threshold divider, five stages of rules and multiplication, nine stages that
// divide by 1000 ten bits at a time, and the output register.
// One word enters per cycle while the output is not stalled.
// Reset clears only the valid bits; the data registers hold whatever they held.
// A stall at the output freezes the whole pipeline in place, so nothing is lost or repeated,
// and the input is stalled in the same cycle.
`timescale 1ns / 1ps
module latency_loss_utility_calc_unit (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            in_valid_i,
  output logic                            in_stall_o,
  input  logic [llu_pkg::RateW-1:0]       send_rate_i,
  input  logic [llu_pkg::CntW-1:0]        delivered_count_i,
  input  logic [llu_pkg::CntW-1:0]        lost_count_i,
  input  logic [llu_pkg::MssW-1:0]        segment_size_i,
  input  logic signed [llu_pkg::DurW-1:0] send_duration_us_i,
  input  logic signed [llu_pkg::DurW-1:0] recv_duration_us_i,
  input  logic [llu_pkg::RttW-1:0]        start_rtt_us_i,
  input  logic [llu_pkg::RttW-1:0]        end_rtt_us_i,
  input  logic                            in_start_mode_i,
  output logic                            out_valid_o,
  input  logic                            out_stall_i,
  output logic signed [llu_pkg::UtilW-1:0] utility_o,
  output logic                            none_delivered_o
);
  import llu_pkg::*;

  localparam int SumW = UqW + 2;
  localparam int CurW = 2 * LimbW;
  localparam int MulW = CurW + RecipW;

  // The whole pipeline moves together unless a finished word is held at the output.
  logic en;
  logic out_vld_q;
  assign en         = !(out_vld_q && out_stall_i);
  assign in_stall_o = !en;

  // Front stages.
  logic   fr_vld;
  front_t fr;

  llu_front u_front (
    .clk_i              (clk_i),
    .rst_ni             (rst_ni),
    .en_i               (en),
    .valid_i            (in_valid_i),
    .send_rate_i        (send_rate_i),
    .delivered_count_i  (delivered_count_i),
    .lost_count_i       (lost_count_i),
    .segment_size_i     (segment_size_i),
    .send_duration_us_i (send_duration_us_i),
    .recv_duration_us_i (recv_duration_us_i),
    .start_rtt_us_i     (start_rtt_us_i),
    .end_rtt_us_i       (end_rtt_us_i),
    .in_start_mode_i    (in_start_mode_i),
    .valid_o            (fr_vld),
    .front_o            (fr)
  );

  // Throughput, inflation and loss dividers run side by side with equal depth.
  logic             d1_vld, d3_vld, d4_vld;
  logic [ThptW-1:0] q1, q3, q4;
  side1_t           s1;
  logic             send_pos, start;

  llu_div #(
    .NUM_W (ThptW), .DEN_W (DenW), .Q_W (ThptW), .SIDE_W ($bits(side1_t))
  ) u_div_thpt (
    .clk_i (clk_i), .rst_ni (rst_ni), .en_i (en), .valid_i (fr_vld),
    .num_i (fr.thpt_num), .den_i (fr.recv_den), .side_i (fr.side),
    .valid_o (d1_vld), .quot_o (q1), .side_o (s1)
  );

  llu_div #(
    .NUM_W (RttKW), .DEN_W (DenW), .Q_W (ThptW), .SIDE_W (1)
  ) u_div_infl (
    .clk_i (clk_i), .rst_ni (rst_ni), .en_i (en), .valid_i (fr_vld),
    .num_i (fr.rtt_k), .den_i (fr.send_den), .side_i (fr.send_pos),
    .valid_o (d3_vld), .quot_o (q3), .side_o (send_pos)
  );

  llu_div #(
    .NUM_W (LossNW), .DEN_W (LossDW), .Q_W (ThptW), .SIDE_W (1)
  ) u_div_loss (
    .clk_i (clk_i), .rst_ni (rst_ni), .en_i (en), .valid_i (fr_vld),
    .num_i (fr.loss_num), .den_i (fr.loss_den), .side_i (fr.start),
    .valid_o (d4_vld), .quot_o (q4), .side_o (start)
  );

  // Throughput is zero for a non-positive receive time; the loss ratio is
  // cleared below 100 per mille in start mode; inflation takes the sign of the RTT change.
  logic [ThptW-1:0] thpt;
  logic [LossW-1:0] loss_raw;
  side2_t           s2_in;

  always_comb begin
    thpt     = s1.recv_pos ? q1 : '0;
    loss_raw = q4[LossW-1:0];
    s2_in.rate     = s1.rate;
    s2_in.thpt_pos = (thpt != '0);
    s2_in.rtt_mag  = s1.rtt_mag;
    s2_in.infl_mag = send_pos ? q3[InflW-1:0] : '0;
    s2_in.infl_neg = send_pos && s1.rtt_neg && (q3[InflW-1:0] != '0);
    s2_in.loss     = (start && (loss_raw < LossW'(LossMin))) ? '0 : loss_raw;
    s2_in.start    = start;
    s2_in.none_del = s1.none_del;
  end

  // RTT threshold divider. A zero throughput gives a quotient that is never used.
  logic             d2_vld;
  logic [ThrNW-1:0] thresh;
  side2_t           s2;

  llu_div #(
    .NUM_W (ThrNW), .DEN_W (ThptW), .Q_W (ThrNW), .SIDE_W ($bits(side2_t))
  ) u_div_thr (
    .clk_i (clk_i), .rst_ni (rst_ni), .en_i (en), .valid_i (d1_vld),
    .num_i (s1.thr_num), .den_i (thpt), .side_i (s2_in),
    .valid_o (d2_vld), .quot_o (thresh), .side_o (s2)
  );

  // Inflation rules, penalty and product with the rate.
  logic             ut_vld;
  logic [ProdW-1:0] prod;
  side5_t           s5_in;

  llu_util u_util (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .en_i     (en),
    .valid_i  (d2_vld),
    .thresh_i (thresh),
    .side_i   (s2),
    .valid_o  (ut_vld),
    .prod_o   (prod),
    .side_o   (s5_in)
  );

  // Divide the product by 1000, one ten-bit digit per stage from the top, as in long
  // division. Each stage joins the remainder (below 1000) with the next digit, gets the
  // quotient digit by multiplying with the rounded-up reciprocal of 1000 and a shift,
  // which is exact for values below 2^20, and writes it in place of the digit.
  logic           d5_vld;
  logic [UqW-1:0] q5;
  side5_t         s5;

  logic [NLimb-1:0] dv_q;
  logic [ProdW-1:0] dn_q [NLimb];
  logic [LimbW-1:0] dr_q [NLimb];
  side5_t           ds_q [NLimb];

  for (genvar k = 0; k < NLimb; k++) begin : g_udiv
    logic             v_in;
    logic [ProdW-1:0] n_in, n_d;
    logic [LimbW-1:0] r_in, r_d;
    side5_t           s_in;
    logic [CurW-1:0]  cur;
    logic [MulW-1:0]  mul;
    logic [LimbW-1:0] qd;

    if (k == 0) begin : g_first
      assign v_in = ut_vld;
      assign n_in = prod;
      assign r_in = '0;
      assign s_in = s5_in;
    end else begin : g_next
      assign v_in = dv_q[k-1];
      assign n_in = dn_q[k-1];
      assign r_in = dr_q[k-1];
      assign s_in = ds_q[k-1];
    end

    always_comb begin
      cur = {r_in, n_in[ProdW-1-k*LimbW -: LimbW]};
      mul = MulW'(cur) * MulW'(UtilRecip);
      qd  = mul[RecipSh +: LimbW];
      r_d = LimbW'(cur - CurW'(qd) * CurW'(UtilDiv));
      n_d = n_in;
      n_d[ProdW-1-k*LimbW -: LimbW] = qd;
    end

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        dv_q[k] <= 1'b0;
      end else if (en) begin
        dv_q[k] <= v_in;
      end
    end

    always_ff @(posedge clk_i) begin
      if (en) begin
        dn_q[k] <= n_d;
        dr_q[k] <= r_d;
        ds_q[k] <= s_in;
      end
    end
  end

  assign d5_vld = dv_q[NLimb-1];
  assign q5     = UqW'(dn_q[NLimb-1]);
  assign s5     = ds_q[NLimb-1];

  // Rate plus or minus the quotient, saturated to the signed 64-bit range; zero when nothing was delivered.
  logic signed [SumW-1:0]  sum;
  logic signed [UtilW-1:0] util_d, util_q;
  logic                    none_q;
  logic                    hi_ovf, lo_ovf;

  always_comb begin
    sum = s5.a_neg ? $signed(SumW'(s5.rate) + SumW'(q5))
                   : $signed(SumW'(s5.rate) - SumW'(q5));
    hi_ovf = !sum[SumW-1] && (sum[SumW-2:UtilW-1] != '0);
    lo_ovf = sum[SumW-1] && (sum[SumW-2:UtilW-1] != '1);
    if (s5.none_del) begin
      util_d = '0;
    end else if (hi_ovf) begin
      util_d = {1'b0, {(UtilW-1){1'b1}}};
    end else if (lo_ovf) begin
      util_d = {1'b1, {(UtilW-1){1'b0}}};
    end else begin
      util_d = sum[UtilW-1:0];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_vld_q <= 1'b0;
    end else if (en) begin
      out_vld_q <= d5_vld;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      util_q <= util_d;
      none_q <= s5.none_del;
    end
  end

  assign out_valid_o      = out_vld_q;
  assign utility_o        = util_q;
  assign none_delivered_o = none_q;

  // The three parallel dividers must stay in lockstep.
  a_div_lockstep: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (d1_vld == d3_vld) && (d1_vld == d4_vld))
    else $error("parallel dividers out of step");

  // A finished word from the last divider reaches the output register.
  a_last_to_out: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (en && d5_vld) |=> out_valid_o)
    else $error("word lost before output register");

  // While the output is held, the pipeline does not move.
  a_freeze: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && out_stall_i) |=> $stable(d5_vld) && (!d5_vld || $stable(q5)))
    else $error("pipeline moved during stall");

  // A record with nothing delivered always reports zero utility.
  a_none_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && none_delivered_o) |-> (utility_o == '0))
    else $error("nonzero utility with nothing delivered");

endmodule

[test/testbench.sv]
// Self-checking testbench of the latency/loss utility unit: directed table, then random records.
`timescale 1ns / 1ps
module testbench;
  import llu_pkg::*;

  // Every wait at the end allows well beyond the depth of the pipeline.
  localparam int PipeDepth = 110;
  localparam int RandItems = 950;
  localparam int CycleLimit = 400000;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic in_valid_i = 1'b0;
  logic in_stall_o;
  logic [RateW-1:0] send_rate_i = '0;
  logic [CntW-1:0] delivered_count_i = '0;
  logic [CntW-1:0] lost_count_i = '0;
  logic [MssW-1:0] segment_size_i = 16'd1;
  logic signed [DurW-1:0] send_duration_us_i = '0;
  logic signed [DurW-1:0] recv_duration_us_i = '0;
  logic [RttW-1:0] start_rtt_us_i = '0;
  logic [RttW-1:0] end_rtt_us_i = '0;
  logic in_start_mode_i = 1'b0;
  logic out_valid_o;
  logic out_stall_i = 1'b0;
  logic signed [UtilW-1:0] utility_o;
  logic none_delivered_o;

  latency_loss_utility_calc_unit dut (.*);

  // One monitor interval record as it is driven onto the ports.
  typedef struct {
    logic [RateW-1:0] rate;
    logic [CntW-1:0] dlv;
    logic [CntW-1:0] lost;
    logic [MssW-1:0] mss;
    logic signed [DurW-1:0] sdur;
    logic signed [DurW-1:0] rdur;
    logic [RttW-1:0] srtt;
    logic [RttW-1:0] ertt;
    logic start;
  } record_t;

  typedef struct {
    logic signed [UtilW-1:0] util;
    logic none;
  } utility_word_t;

  // A table row may carry a hand-read expectation; otherwise the predictor decides.
  typedef struct {
    record_t rec;
    logic typed;
    utility_word_t want;
  } table_row_t;

  utility_word_t pending_utils[$];
  int fails = 0;
  int cycles = 0;
  logic quiet_phase = 1'b0;

  initial begin
    forever #5 clk_i = ~clk_i;
  end

  // Predicts the utility of one record with wide signed arithmetic.
  function automatic utility_word_t predict_utility(record_t r);
    utility_word_t w;
    longint thpt, thr, infl, diff, loss, a;
    logic signed [131:0] prod, q, u;
    w.none = 1'b0;
    if (r.dlv == 0) begin
      w.util = '0;
      w.none = 1'b1;
      return w;
    end
    thpt = 0;
    thr = 0;
    infl = 0;
    if (r.rdur > 0) thpt = (64'sd1000000 * longint'(r.dlv) * longint'(r.mss)) / longint'(r.rdur);
    diff = longint'(r.ertt) - longint'(r.srtt);
    if (thpt > 0) thr = (64'sd2000000 * longint'(r.mss)) / thpt;
    if (r.sdur > 0) infl = (64'sd1000 * diff) / longint'(r.sdur);
    if (diff < thr && diff > -thr) infl = 0;
    if (infl < 30 && infl > -30) infl = 0;
    if (infl < 0 && r.start) infl = 0;
    loss = (longint'(r.lost) * 1000) / (longint'(r.lost) + longint'(r.dlv));
    if (r.start && loss < 100) loss = 0;
    a = 900 * infl + 11 * loss;
    prod = $signed({92'd0, r.rate}) * $signed({{68{a[63]}}, a});
    q = prod / 132'sd1000;
    u = $signed({92'd0, r.rate}) - q;
    if (u > 132'sh7FFFFFFFFFFFFFFF) w.util = 64'sh7FFFFFFFFFFFFFFF;
    else if (u < -132'sh8000000000000000) w.util = 64'sh8000000000000000;
    else w.util = u[63:0];
    return w;
  endfunction

  function automatic record_t make_record(logic [RateW-1:0] rate, logic [CntW-1:0] dlv,
      logic [CntW-1:0] lost, logic [MssW-1:0] mss, logic signed [DurW-1:0] sdur,
      logic signed [DurW-1:0] rdur, logic [RttW-1:0] srtt, logic [RttW-1:0] ertt,
      logic start);
    record_t r;
    r.rate = rate; r.dlv = dlv; r.lost = lost; r.mss = mss; r.sdur = sdur;
    r.rdur = rdur; r.srtt = srtt; r.ertt = ertt; r.start = start;
    return r;
  endfunction

  // Random record: mostly realistic intervals, sometimes full-range fields.
  function automatic record_t random_record();
    record_t r;
    int pick;
    pick = $urandom_range(0, 9);
    r.rate = RateW'({$urandom, $urandom});
    if (pick < 3) r.rate = RateW'($urandom_range(0, 100000000));
    r.dlv = (pick == 0) ? '0 : CntW'((pick < 6) ? $urandom_range(1, 2000) : $urandom);
    r.lost = CntW'((pick < 6) ? $urandom_range(0, 300) : $urandom);
    r.mss = MssW'((pick < 6) ? $urandom_range(500, 1500) : $urandom);
    r.sdur = $signed((pick < 7) ? $urandom_range(1000, 200000) : $urandom);
    r.rdur = $signed((pick < 7) ? $urandom_range(1000, 200000) : $urandom);
    r.srtt = RttW'((pick < 6) ? $urandom_range(5000, 100000) : $urandom);
    r.ertt = (pick < 6) ? RttW'(r.srtt + $urandom_range(0, 40000) - 20000)
                        : RttW'($urandom);
    r.start = 1'($urandom);
    return r;
  endfunction

  // Drive one word and hold it until accepted, with random gaps before it.
  task automatic send_record(record_t r);
    if (!quiet_phase && $urandom_range(0, 7) == 0) begin
      in_valid_i <= 1'b0;
      repeat ($urandom_range(1, 19)) @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    send_rate_i <= r.rate;
    delivered_count_i <= r.dlv;
    lost_count_i <= r.lost;
    segment_size_i <= r.mss;
    send_duration_us_i <= r.sdur;
    recv_duration_us_i <= r.rdur;
    start_rtt_us_i <= r.srtt;
    end_rtt_us_i <= r.ertt;
    in_start_mode_i <= r.start;
    do @(posedge clk_i); while (in_stall_o);
  endtask

  // Output side: random stall bursts and the comparison against the oldest expectation.
  initial begin
    utility_word_t want;
    int burst;
    burst = 0;
    forever begin
      @(posedge clk_i);
      cycles++;
      if (rst_ni && out_valid_o && !out_stall_i) begin
        if (pending_utils.size() == 0) begin
          $display("%0t unexpected word: utility %0d none %0b", $time, utility_o,
                   none_delivered_o);
          fails++;
        end else begin
          want = pending_utils.pop_front();
          if (utility_o !== want.util) begin
            $display("%0t utility expected %0d actual %0d", $time, want.util, utility_o);
            fails++;
          end
          if (none_delivered_o !== want.none) begin
            $display("%0t none_delivered expected %0b actual %0b", $time, want.none,
                     none_delivered_o);
            fails++;
          end
        end
      end
      if (burst > 0) burst--;
      else if (!quiet_phase && $urandom_range(0, 15) == 0) burst = $urandom_range(1, 19);
      out_stall_i <= (burst > 0);
      if (cycles > CycleLimit) begin
        $display("[FAIL] regression broken");
        $finish;
      end
    end
  end

  initial begin
    table_row_t rows[$];
    table_row_t row;
    record_t rec;
    int wait_cycles;
    // Nothing delivered: zero utility with the flag, whatever the rest says.
    row.typed = 1'b1;
    row.want.util = 0; row.want.none = 1'b1;
    row.rec = make_record('1, 0, '1, '1, 32'sh7FFFFFFF, 32'sh7FFFFFFF, '1, 0, 1'b1);
    rows.push_back(row);
    // No loss, no inflation: utility equals the rate.
    row.want.none = 1'b0;
    row.want.util = 64'd1099511627775;
    row.rec = make_record('1, 1, 0, 1, 0, 0, 100, 100, 1'b0);
    rows.push_back(row);
    row.want.util = 0;
    row.rec = make_record(0, '1, '1, '1, 32'sh7FFFFFFF, 32'sh7FFFFFFF, '1, 0, 1'b0);
    rows.push_back(row);
    row.typed = 1'b0;
    // Extremes of durations, RTT jumps both ways, start mode, small thresholds.
    rows.push_back('{make_record('1, '1, '1, '1, 1, 1, 0, '1, 1'b0), 0, row.want});
    rows.push_back('{make_record('1, '1, 0, '1, 1, 1, '1, 0, 1'b0), 0, row.want});
    rows.push_back('{make_record('1, '1, 0, '1, 1, 1, '1, 0, 1'b1), 0, row.want});
    rows.push_back('{make_record('1, 1, '1, 1, 32'sh80000000, 32'sh80000000, 0, '1, 1'b0),
                     0, row.want});
    rows.push_back('{make_record('1, 1, '1, 1, -1, -1, 0, '1, 1'b1), 0, row.want});
    rows.push_back('{make_record(1000000, 100, 5, 1460, 100000, 100000, 20000, 20030, 1'b0),
                     0, row.want});
    rows.push_back('{make_record(1000000, 100, 5, 1460, 100000, 100000, 20000, 25000, 1'b0),
                     0, row.want});
    rows.push_back('{make_record(1000000, 100, 5, 1460, 1000, 1000, 20000, 20040, 1'b1),
                     0, row.want});
    rows.push_back('{make_record(1000000, 100, 20, 1460, 1000, 1000, 20000, 20040, 1'b1),
                     0, row.want});
    rows.push_back('{make_record(1000000, 100, 9, 1460, 1000, 0, 20000, 19000, 1'b1),
                     0, row.want});
    rows.push_back('{make_record(1000000, 100, 9, 0, 1000, 1000, 20000, 19000, 1'b0),
                     0, row.want});
    rows.push_back('{make_record(5, 3, 0, 1, 1000, 2147483647, 0, 200, 1'b0), 0, row.want});

    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    foreach (rows[i]) begin
      pending_utils.push_back(rows[i].typed ? rows[i].want : predict_utility(rows[i].rec));
      send_record(rows[i].rec);
    end
    in_valid_i <= 1'b0;
    // Hold the sender off until the pipeline has drained once.
    while (pending_utils.size() != 0) @(posedge clk_i);

    for (int n = 0; n < RandItems; n++) begin
      if (n == RandItems - 150) quiet_phase = 1'b1;
      rec = random_record();
      pending_utils.push_back(predict_utility(rec));
      send_record(rec);
    end
    in_valid_i <= 1'b0;

    wait_cycles = 0;
    while (pending_utils.size() != 0 && wait_cycles < 20 * PipeDepth + 1000) begin
      @(posedge clk_i);
      wait_cycles++;
    end
    repeat (2 * PipeDepth) @(posedge clk_i);
    if (fails == 0 && pending_utils.size() == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule
